### hdl/mau_pkg.sv
// opcode and state codes for the modular arithmetic unit
package mau_pkg;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_POW  = 3'd4;
	localparam logic [2:0] OP_INV  = 3'd5;
	localparam logic [2:0] OP_NEG  = 3'd6;
	localparam logic [2:0] OP_NONE = 3'd7;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIV   = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_RA    = 4'd3;
	localparam logic [3:0] ST_RB    = 4'd4;
	localparam logic [3:0] ST_DISP  = 4'd5;
	localparam logic [3:0] ST_ELOOP = 4'd6;
	localparam logic [3:0] ST_EQ    = 4'd7;
	localparam logic [3:0] ST_EUPD  = 4'd8;
	localparam logic [3:0] ST_MDONE = 4'd9;
	localparam logic [3:0] ST_PBIT  = 4'd10;
	localparam logic [3:0] ST_PSQ   = 4'd11;
	localparam logic [3:0] ST_PMUL  = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;

	localparam int unsigned MOD_RESET = 17;

endpackage

### hdl/modular_arithmetic_unit_core.sv
// modular alu: add, sub, mul, div, pow, inverse and negate over a programmable modulus
// A request is worked on under a sequencer by modular adders and a one-bit-per-cycle restoring
// divider. Operand reduction divides a and then b by the modulus; add, sub and negate finish
// right after it. A multiply doubles, then adds on a set bit, per bit of the multiplier. Each
// extended Euclid step is one division plus one multiply, so an inverse is up to about 1.5*WIDTH
// such steps. Power costs one multiply per exponent bit and one more per set bit, plus an
// inverse for a negative exponent. The input is stalled while a request is worked on; a
// finished result waits in the output register while the next request is taken. A modulus
// below two gives zero for everything.
module modular_arithmetic_unit_core
	import mau_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [WIDTH-1:0]        cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              opcode,
	input  logic signed [WIDTH-1:0] operand_a,
	input  logic signed [WIDTH-1:0] operand_b,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [WIDTH-1:0]        result,
	output logic                    no_inverse
);

	localparam int CW  = $clog2(WIDTH);
	localparam int PCW = $clog2(WIDTH + 1);

	function automatic logic [WIDTH-1:0] madd(input logic [WIDTH-1:0] x, input logic [WIDTH-1:0] y,
		input logic [WIDTH-1:0] m);
		logic [WIDTH:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) s = s - {1'b0, m};
		return s[WIDTH-1:0];
	endfunction

	function automatic logic [WIDTH-1:0] mneg(input logic [WIDTH-1:0] x, input logic [WIDTH-1:0] m);
		return (x != '0) ? m - x : '0;
	endfunction

	logic [3:0]       state_q, div_ret_q, mul_ret_q;
	logic [WIDTH-1:0] m_q;
	logic [2:0]       op_q;
	logic             a_neg_q, b_neg_q;
	logic [WIDTH-1:0] bmag_q, a_q, b_q;
	logic [WIDTH-1:0] dvd_q, dvs_q, rem_q, quo_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] mx_q, my_q, macc_q;
	logic             ph_q;
	logic [WIDTH-1:0] eg_q, er_q, c0_q, c1_q;
	logic [WIDTH-1:0] pacc_q, pbase_q, pe_q;
	logic [PCW-1:0]   pcnt_q;
	logic [WIDTH-1:0] res_q;
	logic             err_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] result_q;
	logic             no_inverse_q;

	logic [WIDTH-1:0] ua, ub, amag, bmag, red;
	logic [WIDTH:0]   dtrial;
	logic             dge;

	assign ua   = operand_a;
	assign ub   = operand_b;
	assign amag = ua[WIDTH-1] ? ~ua + 1'b1 : ua;
	assign bmag = ub[WIDTH-1] ? ~ub + 1'b1 : ub;

	assign dtrial = {rem_q, dvd_q[WIDTH-1]};
	assign dge    = dtrial >= {1'b0, dvs_q};

	// signed reduction fix-up: a negative value with nonzero remainder maps to m - r
	always_comb begin
		if (state_q == ST_RA) red = (a_neg_q && rem_q != '0) ? m_q - rem_q : rem_q;
		else red = (b_neg_q && rem_q != '0) ? m_q - rem_q : rem_q;
	end

	assign in_stall   = state_q != ST_IDLE;
	assign out_valid  = out_valid_q;
	assign result     = result_q;
	assign no_inverse = no_inverse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= WIDTH'(MOD_RESET);
		end else if (cfg_we) begin
			m_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			result_q     <= res_q;
			no_inverse_q <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_ret_q <= ST_IDLE;
			mul_ret_q <= ST_IDLE;
			cnt_q     <= '0;
			ph_q      <= 1'b0;
			pcnt_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						a_neg_q <= ua[WIDTH-1];
						b_neg_q <= ub[WIDTH-1];
						bmag_q  <= bmag;
						res_q   <= '0;
						err_q   <= 1'b0;
						if (m_q < WIDTH'(2) || opcode == OP_NONE) begin
							state_q <= ST_OUT;
						end else begin
							dvd_q     <= amag;
							dvs_q     <= m_q;
							rem_q     <= '0;
							cnt_q     <= '0;
							div_ret_q <= ST_RA;
							state_q   <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q <= dge ? WIDTH'(dtrial - {1'b0, dvs_q}) : dtrial[WIDTH-1:0];
					quo_q <= {quo_q[WIDTH-2:0], dge};
					dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(WIDTH - 1)) state_q <= div_ret_q;
				end
				ST_MUL: begin
					// msb first: double the accumulator, then add x on a set bit
					if (!ph_q) begin
						macc_q <= madd(macc_q, macc_q, m_q);
						ph_q   <= 1'b1;
					end else begin
						if (my_q[WIDTH-1]) macc_q <= madd(macc_q, mx_q, m_q);
						my_q  <= {my_q[WIDTH-2:0], 1'b0};
						ph_q  <= 1'b0;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CW'(WIDTH - 1)) state_q <= mul_ret_q;
					end
				end
				ST_RA: begin
					a_q       <= red;
					dvd_q     <= bmag_q;
					rem_q     <= '0;
					cnt_q     <= '0;
					div_ret_q <= ST_RB;
					state_q   <= ST_DIV;
				end
				ST_RB: begin
					b_q     <= red;
					state_q <= ST_DISP;
				end
				ST_DISP: begin
					eg_q   <= m_q;
					c0_q   <= '0;
					c1_q   <= WIDTH'(1);
					pacc_q <= WIDTH'(1);
					pcnt_q <= '0;
					pbase_q <= a_q;
					pe_q   <= bmag_q;
					unique case (op_q)
						OP_ADD: begin
							res_q   <= madd(a_q, b_q, m_q);
							state_q <= ST_OUT;
						end
						OP_SUB: begin
							res_q   <= madd(a_q, mneg(b_q, m_q), m_q);
							state_q <= ST_OUT;
						end
						OP_MUL: begin
							mx_q      <= a_q;
							my_q      <= b_q;
							macc_q    <= '0;
							cnt_q     <= '0;
							ph_q      <= 1'b0;
							mul_ret_q <= ST_MDONE;
							state_q   <= ST_MUL;
						end
						OP_DIV: begin
							er_q    <= b_q;
							state_q <= ST_ELOOP;
						end
						OP_POW: begin
							er_q <= a_q;
							if (b_neg_q) begin
								state_q <= ST_ELOOP;
							end else begin
								state_q <= ST_PBIT;
							end
						end
						OP_INV: begin
							er_q    <= a_q;
							state_q <= ST_ELOOP;
						end
						OP_NEG: begin
							res_q   <= mneg(a_q, m_q);
							state_q <= ST_OUT;
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_ELOOP: begin
					if (er_q != '0) begin
						dvd_q     <= eg_q;
						dvs_q     <= er_q;
						rem_q     <= '0;
						cnt_q     <= '0;
						div_ret_q <= ST_EQ;
						state_q   <= ST_DIV;
					end else if (eg_q != WIDTH'(1)) begin
						err_q   <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						priority if (op_q == OP_DIV) begin
							mx_q      <= a_q;
							my_q      <= c0_q;
							macc_q    <= '0;
							cnt_q     <= '0;
							ph_q      <= 1'b0;
							mul_ret_q <= ST_MDONE;
							state_q   <= ST_MUL;
						end else if (op_q == OP_POW) begin
							pbase_q <= c0_q;
							state_q <= ST_PBIT;
						end else begin
							res_q   <= c0_q;
							state_q <= ST_OUT;
						end
					end
				end
				ST_EQ: begin
					// quotient is at most m, so one subtract reduces it
					mx_q      <= (quo_q >= m_q) ? quo_q - m_q : quo_q;
					my_q      <= c1_q;
					macc_q    <= '0;
					cnt_q     <= '0;
					ph_q      <= 1'b0;
					mul_ret_q <= ST_EUPD;
					state_q   <= ST_MUL;
				end
				ST_EUPD: begin
					eg_q    <= er_q;
					er_q    <= rem_q;
					c0_q    <= c1_q;
					c1_q    <= madd(c0_q, mneg(macc_q, m_q), m_q);
					state_q <= ST_ELOOP;
				end
				ST_MDONE: begin
					res_q   <= macc_q;
					state_q <= ST_OUT;
				end
				ST_PBIT: begin
					if (pcnt_q == PCW'(WIDTH)) begin
						res_q   <= pacc_q;
						state_q <= ST_OUT;
					end else begin
						mx_q      <= pacc_q;
						my_q      <= pacc_q;
						macc_q    <= '0;
						cnt_q     <= '0;
						ph_q      <= 1'b0;
						mul_ret_q <= ST_PSQ;
						state_q   <= ST_MUL;
					end
				end
				ST_PSQ: begin
					pacc_q <= macc_q;
					if (pe_q[WIDTH-1]) begin
						mx_q      <= pbase_q;
						my_q      <= macc_q;
						macc_q    <= '0;
						cnt_q     <= '0;
						ph_q      <= 1'b0;
						mul_ret_q <= ST_PMUL;
						state_q   <= ST_MUL;
					end else begin
						pe_q    <= {pe_q[WIDTH-2:0], 1'b0};
						pcnt_q  <= pcnt_q + 1'b1;
						state_q <= ST_PBIT;
					end
				end
				ST_PMUL: begin
					pacc_q  <= macc_q;
					pe_q    <= {pe_q[WIDTH-2:0], 1'b0};
					pcnt_q  <= pcnt_q + 1'b1;
					state_q <= ST_PBIT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
